FILE: rtl/brms_pkg.sv
// Package for the banked register file with privilege-mode switching.
// Holds the command and result word types, mode and action codes, and the
// address map of the shared register memory. Depends on nothing.
package brms_pkg;

  // Command word: one operation on the register file.
  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [4:0]  new_mode;
  } brms_cmd_t;

  // Result word: one per command.
  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] status_word;
    logic [31:0] saved_status;
    logic        irq_taken;
  } brms_result_t;

  // Action codes.
  localparam logic [2:0] ACT_READ    = 3'd0;
  localparam logic [2:0] ACT_WRITE   = 3'd1;
  localparam logic [2:0] ACT_SWITCH  = 3'd2;
  localparam logic [2:0] ACT_CPSR_WR = 3'd3;
  localparam logic [2:0] ACT_IRQ     = 3'd4;
  localparam logic [2:0] ACT_SWI     = 3'd5;

  // Privilege mode codes.
  localparam logic [4:0] MODE_USR  = 5'h10;
  localparam logic [4:0] MODE_FAST = 5'h11;
  localparam logic [4:0] MODE_INTR = 5'h12;
  localparam logic [4:0] MODE_SVC  = 5'h13;
  localparam logic [4:0] MODE_ABT  = 5'h17;
  localparam logic [4:0] MODE_UND  = 5'h1B;
  localparam logic [4:0] MODE_SYS  = 5'h1F;

  // Bank numbers.
  localparam logic [2:0] BANK_USR  = 3'd0;
  localparam logic [2:0] BANK_FAST = 3'd1;
  localparam logic [2:0] BANK_INTR = 3'd2;
  localparam logic [2:0] BANK_SVC  = 3'd3;
  localparam logic [2:0] BANK_ABT  = 3'd4;
  localparam logic [2:0] BANK_UND  = 3'd5;

  // CPSR bits and exception vectors.
  localparam int unsigned BIT_T = 5;
  localparam int unsigned BIT_I = 7;
  localparam logic [31:0] VEC_SWI = 32'h0000_0008;
  localparam logic [31:0] VEC_IRQ = 32'h0000_0018;

  // Memory map: visible registers, then 6 banks of 7 words, then 6 SPSRs.
  localparam int unsigned NUM_BANKS  = 6;
  localparam int unsigned BANK_WORDS = 7;
  localparam int unsigned VIS_REGS   = 16;
  localparam int unsigned MEM_DEPTH  = VIS_REGS + NUM_BANKS * BANK_WORDS + NUM_BANKS;
  localparam int unsigned ADDR_W     = $clog2(MEM_DEPTH);
  localparam logic [ADDR_W-1:0] BANK_BASE = ADDR_W'(VIS_REGS);
  localparam logic [ADDR_W-1:0] SPSR_BASE = ADDR_W'(VIS_REGS + NUM_BANKS * BANK_WORDS);
  localparam logic [ADDR_W-1:0] ADDR_LR   = ADDR_W'(14);
  localparam logic [ADDR_W-1:0] ADDR_PC   = ADDR_W'(15);

  // Swap word numbers: R8..R12 are words 0..4, then SP, LR and SPSR.
  localparam logic [3:0] WORD_R8   = 4'd0;
  localparam logic [3:0] WORD_SP   = 4'd5;
  localparam logic [3:0] WORD_LR   = 4'd6;
  localparam logic [3:0] WORD_SPSR = 4'd7;
  localparam logic [3:0] WORD_END  = 4'd8;

  // Bank that a mode code uses; unknown codes share the user bank.
  function automatic logic [2:0] bank_of(input logic [4:0] mode);
    logic [2:0] b;
    unique case (mode)
      MODE_FAST: b = BANK_FAST;
      MODE_INTR: b = BANK_INTR;
      MODE_SVC:  b = BANK_SVC;
      MODE_ABT:  b = BANK_ABT;
      MODE_UND:  b = BANK_UND;
      default:   b = BANK_USR;
    endcase
    return b;
  endfunction

  // Visible register address of a swap word (SPSR has none in memory).
  function automatic logic [ADDR_W-1:0] vis_addr(input logic [3:0] k);
    logic [ADDR_W-1:0] a;
    unique case (k)
      WORD_SP: a = ADDR_W'(13);
      WORD_LR: a = ADDR_W'(14);
      default: a = ADDR_W'(8) + ADDR_W'(k);
    endcase
    return a;
  endfunction

  // Banked store address of a swap word for a bank. R8..R12 are kept only
  // in the user bank and the FIQ bank.
  function automatic logic [ADDR_W-1:0] bank_addr(input logic [2:0] b, input logic [3:0] k);
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] a;
    base = BANK_BASE + ADDR_W'(b) * ADDR_W'(BANK_WORDS);
    unique case (k)
      WORD_SP:   a = base;
      WORD_LR:   a = base + ADDR_W'(1);
      WORD_SPSR: a = SPSR_BASE + ADDR_W'(b);
      default: begin
        a = BANK_BASE + ((b == BANK_FAST) ? ADDR_W'(BANK_WORDS) : ADDR_W'(0))
            + ADDR_W'(2) + ADDR_W'(k);
      end
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/banked_register_mode_switch.sv
// Banked register file with privilege-mode switching and exception entry.
// Holds all register words in one synchronous memory with a registered read.
// Depends on brms_pkg for the command and result types and the address map.
//
// Usage: a command word on cmd is taken at a rising edge where start is high
// and busy is low. Each command gives exactly one result word on result,
// marked by a one-cycle done strobe; the receiver has no way to hold it off.
// busy is high while a command is being worked on and drops in the cycle
// that done is shown, so the next command can be taken then.
//
// Work done after the accepting edge, set by the single read and single
// write port of the register memory:
//   register write, mode change within a bank, masked IRQ: no memory sequence
//   register read: one memory read
//   mode change across banks: SP, LR and SPSR swapped a word at a time, then
//   the new SPSR loaded; into or out of FIQ: R8..R12 swapped as well
//   IRQ or SWI entry: its mode change, then PC read, LR write and PC write
// Reset (rst, synchronous) clears control state and marks every memory word
// as unwritten, so it reads as zero; the mode returns to system mode.
module banked_register_mode_switch (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  brms_pkg::brms_cmd_t   cmd,
  output logic                  done,
  output brms_pkg::brms_result_t result
);

  localparam int unsigned AW = brms_pkg::ADDR_W;
  localparam int unsigned DEPTH = brms_pkg::MEM_DEPTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SWAP,
    S_EXC_RD,
    S_EXC_LR,
    S_EXC_PC
  } state_t;

  state_t      state;
  logic [4:0]  cur_mode;
  logic [31:0] status_reg;
  logic [31:0] spsr_reg;
  logic [31:0] old_status;
  logic [31:0] lr_delta;
  logic [31:0] vector;
  logic        exc_pending;
  logic [2:0]  old_bank;
  logic [2:0]  new_bank;
  logic [3:0]  word;
  logic [3:0]  first_word;
  logic        phase;
  logic [31:0] read_out;
  logic        taken_out;

  // Register memory and its per-word written marks.
  logic [31:0]   mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [31:0]   rdata;
  logic          rvalid;
  logic [31:0]   rd_eff;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_wdata;

  // Decode of the command at acceptance.
  logic        accept;
  logic        is_exc;
  logic        irq_ok;
  logic [4:0]  target_mode;
  logic [2:0]  tgt_bank;
  logic [2:0]  cur_bank;
  logic        need_swap;
  logic        fiq_swap;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign rd_eff = rvalid ? rdata : 32'd0;
  assign irq_ok = !status_reg[brms_pkg::BIT_I];

  // Work out the mode a command moves to and whether banks must swap.
  always_comb begin
    is_exc      = 1'b0;
    target_mode = cur_mode;
    case (cmd.action)
      brms_pkg::ACT_SWITCH:  target_mode = cmd.new_mode;
      brms_pkg::ACT_CPSR_WR: target_mode = cmd.write_data[4:0];
      brms_pkg::ACT_IRQ: begin
        if (irq_ok) begin
          is_exc      = 1'b1;
          target_mode = brms_pkg::MODE_INTR;
        end
      end
      brms_pkg::ACT_SWI: begin
        is_exc      = 1'b1;
        target_mode = brms_pkg::MODE_SVC;
      end
      default: target_mode = cur_mode;
    endcase
    tgt_bank  = brms_pkg::bank_of(target_mode);
    cur_bank  = brms_pkg::bank_of(cur_mode);
    need_swap = (target_mode != cur_mode) && (tgt_bank != cur_bank);
    fiq_swap  = (tgt_bank == brms_pkg::BANK_FAST) || (cur_bank == brms_pkg::BANK_FAST);
  end

  // Memory port control. The swap works word by word: read the visible
  // word, then read the new bank word while the old bank takes the visible
  // value; the new value lands in the visible word (for SPSR, in spsr_reg) in the next cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = brms_pkg::ADDR_PC;
    mem_wdata = rd_eff;
    mem_raddr = AW'(cmd.reg_index);
    unique case (state)
      S_IDLE: begin
        if (accept && cmd.action == brms_pkg::ACT_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cmd.reg_index);
          mem_wdata = cmd.write_data;
        end
      end
      S_SWAP: begin
        if (!phase) begin
          if (word != brms_pkg::WORD_END) begin
            mem_raddr = brms_pkg::vis_addr(word);
          end
          if (word != first_word && word != brms_pkg::WORD_END) begin
            mem_we    = 1'b1;
            mem_waddr = brms_pkg::vis_addr(word - 4'd1);
          end
        end else begin
          mem_raddr = brms_pkg::bank_addr(new_bank, word);
          mem_we    = 1'b1;
          mem_waddr = brms_pkg::bank_addr(old_bank, word);
          mem_wdata = (word == brms_pkg::WORD_SPSR) ? spsr_reg : rd_eff;
        end
      end
      S_EXC_RD: mem_raddr = brms_pkg::ADDR_PC;
      S_EXC_LR: begin
        mem_we    = 1'b1;
        mem_waddr = brms_pkg::ADDR_LR;
        mem_wdata = rd_eff + lr_delta;
      end
      S_EXC_PC: begin
        mem_we    = 1'b1;
        mem_waddr = brms_pkg::ADDR_PC;
        mem_wdata = vector;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Memory array with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Written marks: an unwritten word reads as its reset value of zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (mem_we) begin
        written[mem_waddr] <= 1'b1;
      end
      rvalid <= written[mem_raddr];
    end
  end

  // Sequencer, status registers and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_mode    <= brms_pkg::MODE_SYS;
      status_reg  <= 32'(brms_pkg::MODE_SYS);
      spsr_reg    <= 32'd0;
      done        <= 1'b0;
      exc_pending <= 1'b0;
      phase       <= 1'b0;
      word        <= brms_pkg::WORD_R8;
      first_word  <= brms_pkg::WORD_R8;
      read_out    <= 32'd0;
      taken_out   <= 1'b0;
      old_status  <= 32'd0;
      old_bank    <= brms_pkg::BANK_USR;
      new_bank    <= brms_pkg::BANK_USR;
      lr_delta    <= 32'd0;
      vector      <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // Commands with no memory sequence finish in the next cycle.
          done <= accept && (cmd.action != brms_pkg::ACT_READ) && !need_swap && !is_exc;
          if (accept) begin
            read_out    <= 32'd0;
            taken_out   <= is_exc && (cmd.action == brms_pkg::ACT_IRQ);
            exc_pending <= is_exc;
            old_status  <= status_reg;
            old_bank    <= cur_bank;
            new_bank    <= tgt_bank;
            phase       <= 1'b0;
            word        <= fiq_swap ? brms_pkg::WORD_R8 : brms_pkg::WORD_SP;
            first_word  <= fiq_swap ? brms_pkg::WORD_R8 : brms_pkg::WORD_SP;
            case (cmd.action) inside
              brms_pkg::ACT_SWITCH: begin
                cur_mode   <= target_mode;
                status_reg <= {status_reg[31:5], target_mode};
              end
              brms_pkg::ACT_CPSR_WR: begin
                cur_mode   <= target_mode;
                status_reg <= cmd.write_data;
              end
              brms_pkg::ACT_IRQ, brms_pkg::ACT_SWI: begin
                // Exception entry: new mode, ARM state, interrupts masked.
                if (is_exc) begin
                  cur_mode   <= target_mode;
                  status_reg <= ({status_reg[31:5], target_mode}
                                 & ~(32'd1 << brms_pkg::BIT_T))
                                | (32'd1 << brms_pkg::BIT_I);
                end
              end
              default: cur_mode <= cur_mode;
            endcase
            // LR offset from PC: IRQ returns past the instruction, SWI to it.
            if (cmd.action == brms_pkg::ACT_IRQ) begin
              lr_delta <= status_reg[brms_pkg::BIT_T] ? 32'd2 : 32'd0;
              vector   <= brms_pkg::VEC_IRQ;
            end else begin
              lr_delta <= status_reg[brms_pkg::BIT_T] ? 32'hFFFF_FFFE : 32'hFFFF_FFFC;
              vector   <= brms_pkg::VEC_SWI;
            end
            if (cmd.action == brms_pkg::ACT_READ) begin
              state <= S_READ;
            end else if (need_swap) begin
              state <= S_SWAP;
            end else if (is_exc) begin
              state <= S_EXC_RD;
            end
          end
        end
        S_READ: begin
          read_out <= rd_eff;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        S_SWAP: begin
          done <= !phase && (word == brms_pkg::WORD_END) && !exc_pending;
          if (!phase) begin
            if (word == brms_pkg::WORD_END) begin
              spsr_reg <= rd_eff;
              if (exc_pending) begin
                state <= S_EXC_RD;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              phase <= 1'b1;
            end
          end else begin
            phase <= 1'b0;
            word  <= word + 4'd1;
          end
        end
        S_EXC_RD: begin
          done  <= 1'b0;
          state <= S_EXC_LR;
        end
        S_EXC_LR: begin
          done     <= 1'b0;
          spsr_reg <= old_status;
          state    <= S_EXC_PC;
        end
        S_EXC_PC: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word.
  always_comb begin
    result.read_data    = read_out;
    result.status_word  = status_reg;
    result.saved_status = spsr_reg;
    result.irq_taken    = taken_out;
  end

  // A result is only shown once the sequencer has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while sequencer busy");

  // Every accepted command either completes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command made no progress");

  // The swap never reads and writes the same memory word in one cycle.
  a_swap_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWAP && mem_we) |-> mem_waddr != mem_raddr)
    else $error("swap read and write hit the same word");

  // A taken IRQ leaves interrupts masked.
  a_irq_masks: assert property (@(posedge clk) disable iff (rst)
    (done && result.irq_taken) |-> status_reg[brms_pkg::BIT_I])
    else $error("taken IRQ left I bit clear");

endmodule

FILE: tb/sv/brms_result_checker.sv
// Result checker for the banked register file with mode switching.
// Follows the command and result channels, keeps a shadow of the register file
// to predict each result word, and counts mismatches. Depends on brms_pkg.
module brms_result_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  brms_pkg::brms_cmd_t    cmd,
  input  logic                   done,
  input  brms_pkg::brms_result_t result,
  output int                     outstanding,
  output int                     fail_count
);

  // Slot layout of one shadow bank: SP, LR, then R8..R12.
  localparam int unsigned SLOT_SP = 0;
  localparam int unsigned SLOT_LR = 1;
  localparam int unsigned SLOT_HI = 2;

  logic [31:0]  shadow_regs [brms_pkg::VIS_REGS];
  logic [31:0]  shadow_bank [brms_pkg::NUM_BANKS][brms_pkg::BANK_WORDS];
  logic [31:0]  shadow_bank_spsr [brms_pkg::NUM_BANKS];
  logic [4:0]   shadow_mode;
  logic [31:0]  shadow_cpsr;
  logic [31:0]  shadow_spsr;
  brms_pkg::brms_result_t result_words_due [$];
  int           errs = 0;

  assign fail_count = errs;

  // Bank that holds the private SP, LR and SPSR of a mode.
  function automatic logic [2:0] bank_for_mode(input logic [4:0] m);
    logic [2:0] b;
    case (m)
      brms_pkg::MODE_FAST: b = brms_pkg::BANK_FAST;
      brms_pkg::MODE_INTR: b = brms_pkg::BANK_INTR;
      brms_pkg::MODE_SVC:  b = brms_pkg::BANK_SVC;
      brms_pkg::MODE_ABT:  b = brms_pkg::BANK_ABT;
      brms_pkg::MODE_UND:  b = brms_pkg::BANK_UND;
      default:             b = brms_pkg::BANK_USR;
    endcase
    return b;
  endfunction

  task automatic clear_shadow();
    int unsigned i;
    int unsigned k;
    for (i = 0; i < brms_pkg::VIS_REGS; i++) shadow_regs[i] = '0;
    for (i = 0; i < brms_pkg::NUM_BANKS; i++) begin
      shadow_bank_spsr[i] = '0;
      for (k = 0; k < brms_pkg::BANK_WORDS; k++) shadow_bank[i][k] = '0;
    end
    shadow_mode = brms_pkg::MODE_SYS;
    shadow_cpsr = 32'(brms_pkg::MODE_SYS);
    shadow_spsr = '0;
  endtask

  // Mode change: swap SP, LR and SPSR across banks, and R8..R12 when FIQ
  // is entered or left.
  task automatic move_to_mode(input logic [4:0] m);
    logic [2:0]  nb;
    logic [2:0]  ob;
    logic [2:0]  from_hi;
    logic [2:0]  to_hi;
    int unsigned k;
    if (m == shadow_mode) return;
    nb = bank_for_mode(m);
    ob = bank_for_mode(shadow_mode);
    if (nb != ob) begin
      if (m == brms_pkg::MODE_FAST || shadow_mode == brms_pkg::MODE_FAST) begin
        from_hi = (ob == brms_pkg::BANK_FAST) ? brms_pkg::BANK_FAST : brms_pkg::BANK_USR;
        to_hi   = (nb == brms_pkg::BANK_FAST) ? brms_pkg::BANK_FAST : brms_pkg::BANK_USR;
        for (k = 0; k < 5; k++) shadow_bank[from_hi][SLOT_HI + k] = shadow_regs[8 + k];
        for (k = 0; k < 5; k++) shadow_regs[8 + k] = shadow_bank[to_hi][SLOT_HI + k];
      end
      shadow_bank[ob][SLOT_SP] = shadow_regs[13];
      shadow_bank[ob][SLOT_LR] = shadow_regs[14];
      shadow_regs[13] = shadow_bank[nb][SLOT_SP];
      shadow_regs[14] = shadow_bank[nb][SLOT_LR];
      shadow_bank_spsr[ob] = shadow_spsr;
      shadow_spsr = shadow_bank_spsr[nb];
    end
    shadow_mode = m;
  endtask

  // Exception entry: bank in, save the old CPSR, link back from PC, vector.
  task automatic take_exception(input logic [4:0] m, input logic [31:0] vector,
                                input logic [31:0] extra);
    logic [31:0] prior;
    logic [31:0] step_back;
    prior = shadow_cpsr;
    step_back = prior[brms_pkg::BIT_T] ? 32'd2 : 32'd4;
    move_to_mode(m);
    shadow_cpsr[4:0] = m;
    shadow_regs[14] = shadow_regs[15] - step_back + extra;
    shadow_regs[15] = vector;
    shadow_cpsr[brms_pkg::BIT_T] = 1'b0;
    shadow_spsr = prior;
    shadow_cpsr[brms_pkg::BIT_I] = 1'b1;
  endtask

  // Applies one command word to the shadow and forms its result word.
  task automatic step_register_file(input brms_pkg::brms_cmd_t c,
                                    output brms_pkg::brms_result_t r);
    r = '0;
    case (c.action)
      brms_pkg::ACT_READ:  r.read_data = shadow_regs[c.reg_index];
      brms_pkg::ACT_WRITE: shadow_regs[c.reg_index] = c.write_data;
      brms_pkg::ACT_SWITCH: begin
        move_to_mode(c.new_mode);
        shadow_cpsr[4:0] = c.new_mode;
      end
      brms_pkg::ACT_CPSR_WR: begin
        shadow_cpsr = c.write_data;
        move_to_mode(c.write_data[4:0]);
      end
      brms_pkg::ACT_IRQ: begin
        if (!shadow_cpsr[brms_pkg::BIT_I]) begin
          take_exception(brms_pkg::MODE_INTR, brms_pkg::VEC_IRQ, 32'd4);
          r.irq_taken = 1'b1;
        end
      end
      brms_pkg::ACT_SWI: take_exception(brms_pkg::MODE_SVC, brms_pkg::VEC_SWI, 32'd0);
      default: ;
    endcase
    r.status_word  = shadow_cpsr;
    r.saved_status = shadow_spsr;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  // Results are matched before new commands are queued, since a result and
  // the next accepted command can share one edge.
  always @(posedge clk) begin : watch_p
    brms_pkg::brms_result_t want;
    brms_pkg::brms_result_t next_word;
    if (rst) begin
      clear_shadow();
      result_words_due.delete();
    end else begin
      if (done) begin
        if (result_words_due.size() == 0) begin
          errs++;
          $error("result word with no command outstanding");
        end else begin
          want = result_words_due.pop_front();
          check_field("read_data", want.read_data, result.read_data);
          check_field("status_word", want.status_word, result.status_word);
          check_field("saved_status", want.saved_status, result.saved_status);
          check_field("irq_taken", 32'(want.irq_taken), 32'(result.irq_taken));
        end
      end
      if (start && !busy) begin
        step_register_file(cmd, next_word);
        result_words_due.push_back(next_word);
      end
    end
    outstanding <= result_words_due.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the testbench for the banked register file with mode switching.
// Drives directed and random command words in bursts and gives the verdict;
// depends on brms_pkg, the block itself and brms_result_checker.
module tb_top;

  // Action codes the block treats as no operation.
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  localparam int unsigned RANDOM_WORDS  = 600;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   done;
  brms_pkg::brms_cmd_t    cmd;
  brms_pkg::brms_result_t result;
  int                     outstanding;
  int                     fail_count;

  banked_register_mode_switch dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  brms_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Presents one command word and holds it until the block takes it.
  task automatic issue(input logic [2:0] act, input logic [3:0] idx,
                       input logic [31:0] data, input logic [4:0] m);
    brms_pkg::brms_cmd_t w;
    w.action     = act;
    w.reg_index  = idx;
    w.write_data = data;
    w.new_mode   = m;
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits until every result word is back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly legal mode codes, now and then any 5-bit code.
  function automatic logic [4:0] pick_mode();
    logic [4:0] m;
    case ($urandom_range(0, 7))
      0:       m = brms_pkg::MODE_USR;
      1:       m = brms_pkg::MODE_FAST;
      2:       m = brms_pkg::MODE_INTR;
      3:       m = brms_pkg::MODE_SVC;
      4:       m = brms_pkg::MODE_ABT;
      5:       m = brms_pkg::MODE_UND;
      6:       m = brms_pkg::MODE_SYS;
      default: m = 5'($urandom);
    endcase
    return m;
  endfunction

  initial begin : stim_p
    int unsigned sent;
    int unsigned run_len;
    int unsigned n;
    int unsigned sel;
    logic [2:0]  act;
    logic [3:0]  idx;
    logic [31:0] data;
    logic [4:0]  m;

    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register extremes and an unaligned PC.
    issue(brms_pkg::ACT_WRITE, 4'd0, 32'h0000_0000, 5'h00);
    issue(brms_pkg::ACT_WRITE, 4'd15, 32'hFFFF_FFFF, 5'h1F);
    issue(brms_pkg::ACT_READ, 4'd15, 32'h0, 5'h0);
    issue(brms_pkg::ACT_WRITE, 4'd13, 32'hA5A5_5A5A, 5'h0);
    issue(brms_pkg::ACT_WRITE, 4'd8, 32'h1234_5678, 5'h0);
    issue(brms_pkg::ACT_WRITE, 4'd12, 32'h9ABC_DEF0, 5'h0);
    // Into FIQ and back: R8..R12 swap along with SP and LR.
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, brms_pkg::MODE_FAST);
    issue(brms_pkg::ACT_READ, 4'd8, 32'h0, 5'h0);
    issue(brms_pkg::ACT_WRITE, 4'd8, 32'hFFFF_FFFF, 5'h0);
    issue(brms_pkg::ACT_WRITE, 4'd13, 32'hF1F1_0013, 5'h0);
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, brms_pkg::MODE_USR);
    issue(brms_pkg::ACT_READ, 4'd8, 32'h0, 5'h0);
    issue(brms_pkg::ACT_READ, 4'd13, 32'h0, 5'h0);
    // User to system shares a bank; then the same mode again.
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, brms_pkg::MODE_SYS);
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, brms_pkg::MODE_SYS);
    // Unknown mode code falls into the user bank.
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, 5'h00);
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, 5'h1F);
    // Supervisor in Thumb state with IRQs open, then IRQ taken and masked.
    issue(brms_pkg::ACT_CPSR_WR, 4'd0, 32'h0000_0033, 5'h0);
    issue(brms_pkg::ACT_IRQ, 4'd0, 32'h0, 5'h0);
    issue(brms_pkg::ACT_IRQ, 4'd0, 32'h0, 5'h0);
    // Exceptions taken from the mode they enter, after one SWI from IRQ mode.
    issue(brms_pkg::ACT_CPSR_WR, 4'd0, 32'(brms_pkg::MODE_INTR), 5'h0);
    issue(brms_pkg::ACT_IRQ, 4'd0, 32'h0, 5'h0);
    issue(brms_pkg::ACT_SWI, 4'd0, 32'h0, 5'h0);
    issue(brms_pkg::ACT_SWI, 4'd0, 32'h0, 5'h0);
    issue(brms_pkg::ACT_READ, 4'd14, 32'h0, 5'h0);
    // Spare action codes change nothing.
    issue(ACT_SPARE_A, 4'd15, 32'hFFFF_FFFF, 5'h1F);
    issue(ACT_SPARE_B, 4'd7, 32'h5555_AAAA, 5'h0A);
    // Full CPSR word, then FIQ entered through the CPSR and left again.
    issue(brms_pkg::ACT_CPSR_WR, 4'd0, 32'hFFFF_FFFF, 5'h0);
    issue(brms_pkg::ACT_CPSR_WR, 4'd0, 32'(brms_pkg::MODE_FAST), 5'h0);
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, brms_pkg::MODE_UND);
    issue(brms_pkg::ACT_SWITCH, 4'd0, 32'h0, brms_pkg::MODE_ABT);
    issue(brms_pkg::ACT_READ, 4'd12, 32'h0, 5'h0);

    // Random bursts: register traffic dominates, with mode changes,
    // CPSR writes and exceptions mixed in.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      run_len = $urandom_range(1, 24);
      for (n = 0; n < run_len && sent < RANDOM_WORDS; n++) begin
        sel  = $urandom_range(0, 99);
        idx  = 4'($urandom);
        data = $urandom;
        m    = 5'($urandom);
        if ($urandom_range(0, 7) == 0) data = $urandom_range(0, 1) ? '1 : '0;
        if (sel < 30) begin
          act = brms_pkg::ACT_READ;
        end else if (sel < 55) begin
          act = brms_pkg::ACT_WRITE;
        end else if (sel < 68) begin
          act = brms_pkg::ACT_SWITCH;
          m = pick_mode();
        end else if (sel < 80) begin
          act = brms_pkg::ACT_CPSR_WR;
          data[4:0] = pick_mode();
          if ($urandom_range(0, 9) < 7) data[brms_pkg::BIT_I] = 1'b0;
        end else if (sel < 90) begin
          act = brms_pkg::ACT_IRQ;
        end else if (sel < 97) begin
          act = brms_pkg::ACT_SWI;
        end else begin
          act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
        end
        issue(act, idx, data, m);
        sent++;
        if (sent == RANDOM_WORDS / 3 || sent == 2 * RANDOM_WORDS / 3) wait_drained();
      end
      // Most bursts end in a gap; some run straight into the next.
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/brms_pkg.sv
rtl/banked_register_mode_switch.sv
tb/sv/brms_result_checker.sv
tb/sv/tb_top.sv
